// File: sv/bia_pkg.sv
// Shared types, constants and helpers for the bitmap identifier allocator.
// No dependencies; every other file refers to it by scoped names.
package bia_pkg;

    // Pool geometry: the used map is stored as 32-bit words
    localparam int POOL_BITS  = 1024;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int NUM_WORDS  = (POOL_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int ID_W       = 16;
    localparam int POOL_CMP_W = ID_W + 1;

    localparam logic [WADDR_W-1:0]    LAST_WORD = WADDR_W'(NUM_WORDS - 1);
    localparam logic [POOL_CMP_W-1:0] POOL_SIZE = POOL_CMP_W'(POOL_BITS);

    // Bits past the end of the pool in the last word always read as used
    localparam int TAIL_BITS = POOL_BITS % WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_PAD =
        (TAIL_BITS == 0) ? '0 : ~((WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1));

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_ID_BASE = 1'b0;
    localparam logic [ID_W-1:0] ID_BASE_RST = 16'd1;

    // Request operation codes
    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    // Map memory access from the sequencer
    typedef struct packed {
        logic                 we;
        logic [WADDR_W-1:0]   waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [WADDR_W-1:0]   raddr;
    } map_req_t;

endpackage

// File: sv/bia_req_if.sv
// Request channel of the allocator: valid/ready plus operation and id.
// Depends on bia_pkg for the id width.
interface bia_req_if;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [bia_pkg::ID_W-1:0] release_id;

    modport source (output valid, output operation, output release_id, input ready);
    modport sink   (input valid, input operation, input release_id, output ready);
endinterface

// File: sv/bia_rsp_if.sv
// Result channel of the allocator: valid/ready plus granted id and status.
// Depends on bia_pkg for the id width.
interface bia_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [bia_pkg::ID_W-1:0] granted_id;
    logic [1:0]               status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface

// File: sv/bia_map_ram.sv
// Used-bit map storage: one write port, one read port, registered read data.
// Depends on bia_pkg for geometry and the access struct.
module bia_map_ram (
    input  logic                          clk,
    input  bia_pkg::map_req_t             mreq,
    output logic [bia_pkg::WORD_BITS-1:0] rdata
);

    logic [bia_pkg::WORD_BITS-1:0] mem [bia_pkg::NUM_WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr] <= mreq.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[mreq.raddr];
    end

endmodule

// File: sv/bia_ffz.sv
// Find-first-zero unit over one map word: lowest clear bit and its index.
// Depends on bia_pkg for the word width.
module bia_ffz (
    input  logic [bia_pkg::WORD_BITS-1:0] word,
    output logic                          found,
    output logic [bia_pkg::BIT_W-1:0]     bit_idx
);

    logic [bia_pkg::WORD_BITS-1:0] free_bits;
    logic [bia_pkg::WORD_BITS-1:0] lowest;

    // Isolate the lowest free bit with the two's complement trick
    assign free_bits = ~word;
    assign lowest    = free_bits & (~free_bits + bia_pkg::WORD_BITS'(1));
    assign found     = |free_bits;

    // One-hot to binary
    always_comb
    begin
        bit_idx = '0;
        for (int b = 0; b < bia_pkg::BIT_W; b++)
        begin
            for (int j = 0; j < bia_pkg::WORD_BITS; j++)
            begin
                if (((j >> b) & 1) == 1)
                begin
                    bit_idx[b] = bit_idx[b] | lowest[j];
                end
            end
        end
    end

endmodule

// File: sv/bia_ctrl.sv
// Sequencer of the allocator: clearing pass, word-by-word scan, release
// read-modify-write and the result register. Depends on bia_pkg, the channel
// interfaces and bia_ffz.
module bia_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bia_pkg::ID_W-1:0]      id_base,
    bia_req_if.sink                       req,
    bia_rsp_if.source                     rsp,
    output bia_pkg::map_req_t             mreq,
    input  logic [bia_pkg::WORD_BITS-1:0] rdata
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_REL   = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [bia_pkg::WADDR_W-1:0]     addr_reg, addr_next;
    logic [bia_pkg::BIT_W-1:0]       bit_reg, bit_next;
    logic [bia_pkg::ID_W-1:0]        granted_reg, granted_next;
    bia_pkg::status_t                status_reg, status_next;

    logic [bia_pkg::WORD_BITS-1:0]   scan_word;
    logic                            ffz_found;
    logic [bia_pkg::BIT_W-1:0]       ffz_bit;
    logic [bia_pkg::ID_W-1:0]        rel_diff;
    logic                            rel_in_range;
    logic [bia_pkg::WADDR_W-1:0]     rel_word;
    logic                            at_last;

    // Release index relative to the base, wrapped to 16 bits
    assign rel_diff     = req.release_id - id_base;
    assign rel_in_range = {1'b0, rel_diff} < bia_pkg::POOL_SIZE;
    assign rel_word     = rel_diff[bia_pkg::WADDR_W+bia_pkg::BIT_W-1:bia_pkg::BIT_W];
    assign at_last      = (addr_reg == bia_pkg::LAST_WORD);

    // Tail bits of the last word count as used
    assign scan_word = at_last ? (rdata | bia_pkg::LAST_PAD) : rdata;

    bia_ffz u_ffz (
        .word    (scan_word),
        .found   (ffz_found),
        .bit_idx (ffz_bit)
    );

    // Next state and map access
    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        bit_next     = bit_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        mreq.we      = 1'b0;
        mreq.waddr   = addr_reg;
        mreq.wdata   = '0;
        mreq.raddr   = addr_reg + bia_pkg::WADDR_W'(1);

        case (state_reg)
            S_CLEAR:
            begin
                mreq.we = 1'b1;
                if (at_last)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + bia_pkg::WADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.operation == bia_pkg::OP_ALLOC)
                    begin
                        mreq.raddr = '0;
                        addr_next  = '0;
                        state_next = S_SCAN;
                    end
                    else if (rel_in_range)
                    begin
                        mreq.raddr = rel_word;
                        addr_next  = rel_word;
                        bit_next   = rel_diff[bia_pkg::BIT_W-1:0];
                        state_next = S_REL;
                    end
                    else
                    begin
                        granted_next = '0;
                        status_next  = bia_pkg::ST_RANGE;
                        state_next   = S_RESP;
                    end
                end
            end
            S_SCAN:
            begin
                // Read of the following word is already in flight
                if (ffz_found)
                begin
                    mreq.we      = 1'b1;
                    mreq.wdata   = rdata | (bia_pkg::WORD_BITS'(1) << ffz_bit);
                    granted_next = id_base + bia_pkg::ID_W'({addr_reg, ffz_bit});
                    status_next  = bia_pkg::ST_OK;
                    state_next   = S_RESP;
                end
                else if (at_last)
                begin
                    granted_next = '0;
                    status_next  = bia_pkg::ST_EXHAUSTED;
                    state_next   = S_RESP;
                end
                else
                begin
                    addr_next = addr_reg + bia_pkg::WADDR_W'(1);
                end
            end
            S_REL:
            begin
                mreq.we      = 1'b1;
                mreq.wdata   = rdata & ~(bia_pkg::WORD_BITS'(1) << bit_reg);
                granted_next = '0;
                status_next  = bia_pkg::ST_OK;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bit_reg     <= bit_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    // Channel outputs
    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = (state_reg == S_RESP);
    assign rsp.granted_id = granted_reg;
    assign rsp.status     = status_reg;

    // One request in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in flight");

    // Map is never written while a result waits
    a_no_write_in_resp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !mreq.we)
        else $error("map written during result beat");

    // Only an ok allocate carries a nonzero id
    a_zero_id_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != bia_pkg::ST_OK |-> rsp.granted_id == '0)
        else $error("nonzero id on error status");

    // Map writes stay inside the pool
    a_write_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.we |-> mreq.waddr <= bia_pkg::LAST_WORD)
        else $error("map write outside pool");

    // An exhausted result only follows a scan of the last word
    a_exhaust_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && state_next == S_RESP && !ffz_found |-> at_last)
        else $error("exhausted before the last word");

endmodule

// File: sv/bitmap_id_allocator.sv
// Top level of the bitmap identifier allocator: APB register, map memory and
// sequencer. Depends on bia_pkg, bia_req_if, bia_rsp_if, bia_map_ram, bia_ctrl.
//
// First-free identifier allocator over a 1024-bit used map kept in a
// 32 x 32-bit memory with one read and one write port. An allocate beat scans
// the map one word per cycle through the find-first-zero unit and returns
// id_base plus the index of the lowest free bit; the scan stops at the first
// word with a free bit, or after the last word when the pool is exhausted. A
// release is a read-modify-write of one word, and an out-of-range release
// goes straight to the result beat. One request is in flight at a time; a new
// request is taken the cycle after the result beat is accepted. After reset a
// clearing pass writes every one of the NUM_WORDS (32) words, during which no
// request is accepted; id_base (offset 0x0) may be written at any time the
// block is idle and does not disturb the map.
module bitmap_id_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bia_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bia_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bia_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    bia_req_if.sink                        req,
    bia_rsp_if.source                      rsp
);

    logic [bia_pkg::ID_W-1:0]      id_base_reg;
    logic                          cfg_wr;
    logic                          sel_id_base;
    bia_pkg::map_req_t             mreq;
    logic [bia_pkg::WORD_BITS-1:0] rdata;

    // Register decode
    assign pready      = 1'b1;
    assign sel_id_base = (paddr[2] == bia_pkg::REG_IDX_ID_BASE);
    assign cfg_wr      = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_base_reg <= bia_pkg::ID_BASE_RST;
        end
        else if (cfg_wr && sel_id_base)
        begin
            id_base_reg <= pwdata[bia_pkg::ID_W-1:0];
        end
    end

    assign prdata = sel_id_base ?
        {{(bia_pkg::APB_DATA_W - bia_pkg::ID_W){1'b0}}, id_base_reg} : '0;

    bia_map_ram u_map (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    bia_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .id_base (id_base_reg),
        .req     (req),
        .rsp     (rsp),
        .mreq    (mreq),
        .rdata   (rdata)
    );

endmodule

// File: tb/tb_bitmap_id_allocator.sv
// Self-checking testbench for bitmap_id_allocator: drives request beats, programs
// id_base over APB and checks every result beat against a used-map predictor.
// Depends on bia_pkg, bia_req_if, bia_rsp_if and the allocator RTL.
module tb_bitmap_id_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 500_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [bia_pkg::APB_ADDR_W-1:0] ADDR_ID_BASE =
        {bia_pkg::REG_IDX_ID_BASE, 2'b00};

    // One expected result beat
    typedef struct packed {
        bia_pkg::op_t             op;
        logic [bia_pkg::ID_W-1:0] id;
        bia_pkg::status_t         st;
    } grant_t;

    // Used-map predictor plus queue of grants still owed by the block
    class id_pool_scoreboard;
        bit                       used_bits [bia_pkg::POOL_BITS];
        logic [bia_pkg::ID_W-1:0] id_base;
        grant_t                   expected_q [$];
        int                       errors;
        int                       n_results;
        int                       n_alloc_ok;
        int                       n_exhausted;
        int                       n_release_ok;
        int                       n_range;

        function new();
            id_base = bia_pkg::ID_BASE_RST;
            foreach (used_bits[i])
                used_bits[i] = 1'b0;
        endfunction

        // Accepted request beat: update the map and queue the grant it owes
        function void note_request(bia_pkg::op_t op, logic [bia_pkg::ID_W-1:0] rid);
            grant_t                   owed;
            logic [bia_pkg::ID_W-1:0] offset;
            int                       slot;
            owed.op = op;
            owed.id = '0;
            owed.st = bia_pkg::ST_OK;
            if (op == bia_pkg::OP_ALLOC)
            begin
                slot = -1;
                for (int i = 0; i < bia_pkg::POOL_BITS && slot < 0; i++)
                    if (!used_bits[i])
                        slot = i;
                if (slot < 0)
                    owed.st = bia_pkg::ST_EXHAUSTED;
                else
                begin
                    used_bits[slot] = 1'b1;
                    owed.id = id_base + bia_pkg::ID_W'(slot);
                end
            end
            else
            begin
                // index wraps modulo 2^16, same as the granted ids
                offset = rid - id_base;
                if (offset < bia_pkg::POOL_BITS)
                    used_bits[offset] = 1'b0;
                else
                    owed.st = bia_pkg::ST_RANGE;
            end
            expected_q.push_back(owed);
        endfunction

        // Accepted result beat: compare with the oldest owed grant
        function void check_result(logic [bia_pkg::ID_W-1:0] gid, logic [1:0] st);
            grant_t owed;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing owed: id=%h status=%0d",
                         $time, gid, st);
                errors++;
                return;
            end
            owed = expected_q.pop_front();
            n_results++;
            case (owed.st)
                bia_pkg::ST_EXHAUSTED: n_exhausted++;
                bia_pkg::ST_RANGE:     n_range++;
                default:               if (owed.op == bia_pkg::OP_ALLOC) n_alloc_ok++;
                                       else n_release_ok++;
            endcase
            if (gid !== owed.id)
            begin
                $display("%0t: granted_id mismatch: expected %h, actual %h",
                         $time, owed.id, gid);
                errors++;
            end
            if (st !== owed.st)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, owed.st, st);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bia_pkg::APB_ADDR_W-1:0] paddr;
    logic [bia_pkg::APB_DATA_W-1:0] pwdata;
    logic [bia_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    bia_req_if req_ch ();
    bia_rsp_if rsp_ch ();

    id_pool_scoreboard pool_sb;
    int                req_idle_pct;
    int                rsp_idle_pct;
    int                hold_left;
    int                n_reg_writes;
    longint            cycle_count;

    bitmap_id_allocator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Result sink: random stalls, plus the long hold-off when requested
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            pool_sb.check_result(rsp_ch.granted_id, rsp_ch.status);

    // One APB transfer: setup then access; entered and left at a falling edge
    task automatic apb_access(input logic is_write,
                              input logic [bia_pkg::APB_ADDR_W-1:0] addr,
                              input logic [bia_pkg::APB_DATA_W-1:0] wdata,
                              output logic [bia_pkg::APB_DATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write id_base, mirror it in the predictor, read it back
    task automatic program_id_base(input logic [bia_pkg::ID_W-1:0] value);
        logic [bia_pkg::APB_DATA_W-1:0] rdata;
        apb_access(1'b1, ADDR_ID_BASE, bia_pkg::APB_DATA_W'(value), rdata);
        pool_sb.id_base = value;
        n_reg_writes++;
        apb_access(1'b0, ADDR_ID_BASE, '0, rdata);
        if (rdata[bia_pkg::ID_W-1:0] !== value)
        begin
            $display("%0t: id_base readback mismatch: expected %h, actual %h",
                     $time, value, rdata[bia_pkg::ID_W-1:0]);
            pool_sb.errors++;
        end
    endtask

    // Offer one request beat; valid stays high on return (at a falling edge)
    task automatic send_request(input bia_pkg::op_t op,
                                input logic [bia_pkg::ID_W-1:0] rid);
        int gap;
        gap = ($urandom_range(99) < req_idle_pct) ? $urandom_range(1, 4) : 0;
        repeat (gap)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.operation  = op;
        req_ch.release_id = rid;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pool_sb.note_request(op, rid);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed grant has come back
    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (pool_sb.expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random mix: allocates, releases inside the pool, and stray ids
    task automatic run_random(input int count);
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send_request(bia_pkg::OP_ALLOC, '0);
            else if (pick < 85)
                send_request(bia_pkg::OP_RELEASE, pool_sb.id_base +
                             bia_pkg::ID_W'($urandom_range(0, bia_pkg::POOL_BITS - 1)));
            else
                send_request(bia_pkg::OP_RELEASE,
                             bia_pkg::ID_W'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        logic [bia_pkg::APB_DATA_W-1:0] rdata;

        pool_sb      = new();
        n_reg_writes = 0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = bia_pkg::OP_ALLOC;
        req_ch.release_id = '0;
        req_idle_pct = 23;
        rsp_idle_pct = 53;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // id_base must read back its reset value
        apb_access(1'b0, ADDR_ID_BASE, '0, rdata);
        if (rdata[bia_pkg::ID_W-1:0] !== bia_pkg::ID_BASE_RST)
        begin
            $display("%0t: id_base reset mismatch: expected %h, actual %h",
                     $time, bia_pkg::ID_BASE_RST, rdata[bia_pkg::ID_W-1:0]);
            pool_sb.errors++;
        end

        // Directed, base 1: first grants, free-id release, ids outside the pool
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_RELEASE, 16'd2);
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_RELEASE, 16'd5);
        send_request(bia_pkg::OP_RELEASE, 16'h0000);
        send_request(bia_pkg::OP_RELEASE, 16'hFFFF);
        send_request(bia_pkg::OP_RELEASE, 16'd1025);
        send_request(bia_pkg::OP_RELEASE, 16'd1024);

        // Allocate a run of ids so the scan crosses several words
        repeat (150) send_request(bia_pkg::OP_ALLOC, '0);

        // Hole at the first bit, free ids at the middle and the top, then refill
        send_request(bia_pkg::OP_RELEASE, 16'd1);
        send_request(bia_pkg::OP_RELEASE, 16'd1024);
        send_request(bia_pkg::OP_RELEASE, 16'd513);
        repeat (4) send_request(bia_pkg::OP_ALLOC, '0);
        wait_drained();

        // Top of the base range; the map keeps its used bits
        program_id_base(16'hFC00);
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_RELEASE, 16'hFFFF);
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_RELEASE, 16'hFBFF);
        send_request(bia_pkg::OP_RELEASE, 16'hFC00);
        run_random(60);
        wait_drained();

        // Requester-heavy idling; long result stall while requests keep coming
        req_idle_pct = 53;
        rsp_idle_pct = 23;
        program_id_base(16'h0000);
        hold_left = HOLD_CYCLES;
        run_random(80);
        wait_drained();
        program_id_base(bia_pkg::ID_W'($urandom_range(0, 65535)));
        run_random(40);
        wait_drained();

        // No idling; bases above the range so grants wrap
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        program_id_base(16'hFFF0);
        run_random(60);
        wait_drained();
        program_id_base(16'hFFFF);
        send_request(bia_pkg::OP_RELEASE, 16'hFFFF);
        send_request(bia_pkg::OP_RELEASE, 16'h0000);
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_ALLOC, '0);
        send_request(bia_pkg::OP_RELEASE, 16'd1022);
        run_random(40);
        wait_drained();

        // Catch any stray beat after the last grant
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d result beats: %0d grants, %0d exhausted, %0d releases,",
                 pool_sb.n_results, pool_sb.n_alloc_ok, pool_sb.n_exhausted,
                 pool_sb.n_release_ok);
        $display("%0d out of range; %0d id_base settings incl. reset and wrapping bases",
                 pool_sb.n_range, n_reg_writes + 1);
        if (pool_sb.errors == 0 && pool_sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/bia_pkg.sv
sv/bia_req_if.sv
sv/bia_rsp_if.sv
sv/bia_map_ram.sv
sv/bia_ffz.sv
sv/bia_ctrl.sv
sv/bitmap_id_allocator.sv
tb/tb_bitmap_id_allocator.sv
